FILE: src/assert_macros.svh
// Assertion macros shared by the double hash table RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define DHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/dht_pkg.sv
// Types and constants of the double hash table.
// No dependencies; imported by every module of the block but dht_ram.
package dht_pkg;

  localparam int unsigned OPC_W     = 2;
  localparam int unsigned KEY_W     = 31;
  localparam int unsigned VAL_W     = 31;
  localparam int unsigned CNT_OUT_W = 10;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

  // secondary hash: step = STEP_MOD - (key mod STEP_MOD)
  localparam int unsigned STEP_W   = 5;
  localparam logic [STEP_W-1:0] STEP_MOD = 5'd17;

  // key is reduced DIGIT_W bits per cycle, most significant digit first
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned N_DIGITS  = 8;
  localparam int unsigned KEY_PAD_W = DIGIT_W * N_DIGITS;
  localparam int unsigned DIG_CNT_W = 3;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [CNT_OUT_W-1:0] probe_count;
    logic                 status;
  } out_item_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_EMPTY = 2'd1,
    RES_FOUND = 2'd2,
    RES_FULL  = 2'd3
  } res_e;

  typedef struct packed {
    logic load;        // capture item, start hashing
    logic hash;        // one digit of key reduction
    logic sweep_init;  // slot pointer to zero
    logic sweep_wr;    // clear one slot, advance pointer
    logic probe_adv;   // move to next slot on probe path
    logic ins_wr;      // store value, mark occupied
    logic res_ld;      // latch result
    res_e res_src;
    logic out_ld;      // move result into output register
  } dht_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic sweep_last;
    logic occ;
    logic match;
    logic bound;
  } dht_sts_t;

endpackage

FILE: src/dht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1021
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dht_datapath.sv
// Datapath: key hashing, probe pointer, slot memory, result and output registers.
// Depends on dht_pkg, dht_ram and assert_macros.svh.
`include "assert_macros.svh"

module dht_datapath import dht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dht_cmd_t  cmd_i,
  output dht_sts_t  sts_o,
  output out_item_t out_item_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned MEM_W  = VAL_W + 1;
  localparam logic [SLOT_W:0]   TS_C   = (SLOT_W+1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]  CNT_TS = CNT_W'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

  logic [KEY_PAD_W-1:0] key_sh_q;
  logic [VAL_W-1:0]     value_q;
  logic [DIG_CNT_W-1:0] dig_q;
  logic [SLOT_W-1:0]    rem_ts_q, rem_ts_d;
  logic [STEP_W-1:0]    rem17_q, rem17_d;
  logic [SLOT_W-1:0]    slot_q;
  logic [STEP_W-1:0]    step_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 res_found_q, res_full_q;
  logic [CNT_W-1:0]     res_cnt_q;
  out_item_t            out_q;

  logic [SLOT_W:0]      next_sum;
  logic [SLOT_W-1:0]    next_slot;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  logic                 mem_we;
  logic [MEM_W-1:0]     mem_wdata, mem_rdata;

  // DIGIT_W shift-and-reduce steps per cycle for both moduli
  always_comb begin
    logic [SLOT_W:0]   r_ts;
    logic [STEP_W:0]   r17;
    logic [DIGIT_W-1:0] digit;
    r_ts  = {1'b0, rem_ts_q};
    r17   = {1'b0, rem17_q};
    digit = key_sh_q[KEY_PAD_W-1 -: DIGIT_W];
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r_ts = {r_ts[SLOT_W-1:0], digit[i]};
      if (r_ts >= TS_C) begin
        r_ts = r_ts - TS_C;
      end
      r17 = {r17[STEP_W-1:0], digit[i]};
      if (r17 >= {1'b0, STEP_MOD}) begin
        r17 = r17 - {1'b0, STEP_MOD};
      end
    end
    rem_ts_d = r_ts[SLOT_W-1:0];
    rem17_d  = r17[STEP_W-1:0];
  end

  assign next_sum  = {1'b0, slot_q} + (SLOT_W+1)'(step_q);
  assign next_slot = (next_sum >= TS_C) ? SLOT_W'(next_sum - TS_C) : next_sum[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_sh_q <= KEY_PAD_W'(in_item_i.key);
      value_q  <= in_item_i.value;
      rem_ts_q <= '0;
      rem17_q  <= '0;
      dig_q    <= '0;
    end else if (cmd_i.hash) begin
      key_sh_q <= key_sh_q << DIGIT_W;
      rem_ts_q <= rem_ts_d;
      rem17_q  <= rem17_d;
      dig_q    <= dig_q + 1'b1;
    end
    if (cmd_i.hash && sts_o.hash_last) begin
      step_q <= STEP_MOD - rem17_d;
      cnt_q  <= CNT_W'(1);
    end else if (cmd_i.probe_adv) begin
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      priority if (cmd_i.sweep_init) begin
        slot_q <= '0;
      end else if (cmd_i.sweep_wr) begin
        slot_q <= sts_o.sweep_last ? '0 : slot_q + 1'b1;
      end else if (cmd_i.hash && sts_o.hash_last) begin
        slot_q <= rem_ts_d;
      end else if (cmd_i.probe_adv) begin
        slot_q <= next_slot;
      end
    end
  end

  assign mem_we    = cmd_i.sweep_wr | cmd_i.ins_wr;
  assign mem_wdata = cmd_i.ins_wr ? {1'b1, value_q} : '0;

  dht_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (slot_q),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      unique case (cmd_i.res_src)
        RES_ZERO: begin
          res_found_q <= 1'b0;
          res_full_q  <= 1'b0;
          res_cnt_q   <= '0;
        end
        RES_EMPTY: begin
          res_found_q <= 1'b0;
          res_full_q  <= 1'b0;
          res_cnt_q   <= cnt_q;
        end
        RES_FOUND: begin
          res_found_q <= 1'b1;
          res_full_q  <= 1'b0;
          res_cnt_q   <= cnt_q;
        end
        RES_FULL: begin
          res_found_q <= 1'b0;
          res_full_q  <= 1'b1;
          res_cnt_q   <= cnt_q;
        end
        default: begin
          res_found_q <= 1'b0;
          res_full_q  <= 1'b0;
          res_cnt_q   <= '0;
        end
      endcase
    end
    if (cmd_i.out_ld) begin
      out_q.found       <= res_found_q;
      out_q.probe_count <= cnt_ext[CNT_OUT_W-1:0];
      out_q.status      <= res_full_q;
    end
  end

  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, res_cnt_q};
  assign out_item_o = out_q;

  assign sts_o.hash_last  = (dig_q == '1);
  assign sts_o.sweep_last = (slot_q == SLOT_LAST);
  assign sts_o.occ        = mem_rdata[MEM_W-1];
  assign sts_o.match      = (mem_rdata[VAL_W-1:0] == value_q);
  assign sts_o.bound      = (cnt_q == CNT_TS);

  `DHT_ASSERT_IMPL(a_adv_in_range, clk_i, rst_ni, cmd_i.probe_adv, ({1'b0, slot_q} < TS_C) && (cnt_q < CNT_TS))
  `DHT_ASSERT_IMPL(a_step_range, clk_i, rst_ni, cmd_i.probe_adv, (step_q != '0) && (step_q <= STEP_MOD))
  `DHT_ASSERT_NEXT(a_hash_loads_home, clk_i, rst_ni, cmd_i.hash && sts_o.hash_last, ({1'b0, slot_q} < TS_C) && (cnt_q == CNT_W'(1)))

endmodule

FILE: src/dht_ctrl.sv
// Controller: sequences reset sweep, hashing, probing, clear and result hand-off.
// Depends on dht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dht_ctrl import dht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [OPC_W-1:0] in_opcode_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output dht_cmd_t         cmd_o,
  input  dht_sts_t         sts_i
);

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_HASH = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_CLR  = 7'b0100000,
    ST_RES  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [OPC_W-1:0] op_q;
  logic             out_valid_q, out_valid_d;
  logic             in_acc;
  dht_cmd_t         cmd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          unique case (in_opcode_i)
            OP_INSERT, OP_SEARCH: state_d = ST_HASH;
            OP_CLEAR: begin
              cmd.sweep_init = 1'b1;
              state_d        = ST_CLR;
            end
            default: begin
              cmd.res_ld  = 1'b1;
              cmd.res_src = RES_ZERO;
              state_d     = ST_RES;
            end
          endcase
        end
      end
      ST_HASH: begin
        cmd.hash = 1'b1;
        if (sts_i.hash_last) begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        priority if (!sts_i.occ) begin
          cmd.ins_wr  = (op_q == OP_INSERT);
          cmd.res_ld  = 1'b1;
          cmd.res_src = RES_EMPTY;
          state_d     = ST_RES;
        end else if (op_q == OP_SEARCH && sts_i.match) begin
          cmd.res_ld  = 1'b1;
          cmd.res_src = RES_FOUND;
          state_d     = ST_RES;
        end else if (sts_i.bound) begin
          cmd.res_ld  = 1'b1;
          cmd.res_src = RES_FULL;
          state_d     = ST_RES;
        end else begin
          cmd.probe_adv = 1'b1;
          state_d       = ST_RD;
        end
      end
      ST_CLR: begin
        cmd.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_src = RES_ZERO;
          state_d     = ST_RES;
        end
      end
      ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_ld = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.out_ld) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      op_q        <= OP_INSERT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        op_q <= in_opcode_i;
      end
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `DHT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, (state_q != ST_IDLE) && (state_q != ST_INIT))
  `DHT_ASSERT_IMPL(a_insert_only_empty, clk_i, rst_ni, cmd.ins_wr, (state_q == ST_CHK) && !sts_i.occ && (op_q == OP_INSERT))
  `DHT_ASSERT_IMPL(a_out_ld_when_free, clk_i, rst_ni, cmd.out_ld, (state_q == ST_RES) && !(out_valid_q && out_stall_i))

endmodule

FILE: src/double_hash_table.sv
// Top level of the double hash table: controller, datapath and slot memory.
// Depends on dht_pkg, dht_ctrl, dht_datapath (which holds dht_ram).
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o   in_item_i  (opcode, key, value)
//   out       output     out_valid_o/out_stall_i out_item_o (found, probe_count, status)
//
// Insert/search: accept, hashing at 4 key bits per cycle, then per probe a registered read
//   of the slot memory (ST_RD, ST_CHK), then the result hand-off (ST_RES).
// Clear: accept, a sweep that empties every slot of the slot memory, then the result.
// After reset a sweep empties the table; in_stall_o stays high during it.
// The output register holds one result; a new item is accepted while it waits.
module double_hash_table import dht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_item_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

FILE: test/dht_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the double hash table: predicts each result from a model of the slot array.
// Watches both channels of double_hash_table and depends on dht_pkg only.
module dht_checker import dht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned miss_cnt_o,
  output int unsigned pend_cnt_o
);

  bit               occupied [TABLE_SIZE];
  logic [VAL_W-1:0] slot_val [TABLE_SIZE];
  out_item_t        expected_q [$];
  int unsigned      miss_cnt;

  function automatic out_item_t walk_table(in_item_t it);
    out_item_t   r;
    int unsigned slot;
    int unsigned step;
    int unsigned n;
    bit          done;
    r = '0;
    if (it.opcode == OP_INSERT || it.opcode == OP_SEARCH) begin
      slot = it.key % TABLE_SIZE;
      step = int'(STEP_MOD) - (it.key % int'(STEP_MOD));
      done = 1'b0;
      for (n = 1; n <= TABLE_SIZE && !done; n++) begin
        if (!occupied[slot]) begin
          if (it.opcode == OP_INSERT) begin
            slot_val[slot] = it.value;
            occupied[slot] = 1'b1;
          end
          r.probe_count = CNT_OUT_W'(n);
          done = 1'b1;
        end else if (it.opcode == OP_SEARCH && slot_val[slot] == it.value) begin
          r.found = 1'b1;
          r.probe_count = CNT_OUT_W'(n);
          done = 1'b1;
        end else begin
          slot = (slot + step) % TABLE_SIZE;
        end
      end
      if (!done) begin
        r.status = 1'b1;
        r.probe_count = CNT_OUT_W'(TABLE_SIZE);
      end
    end else if (it.opcode == OP_CLEAR) begin
      for (n = 0; n < TABLE_SIZE; n++) occupied[n] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) occupied[i] = 1'b0;
      expected_q.delete();
      miss_cnt = 0;
      miss_cnt_o <= 0;
      pend_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%0t: result with none expected: found=%0d count=%0d status=%0d",
                     $realtime, out_item_i.found, out_item_i.probe_count, out_item_i.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_item_i.found !== exp_r.found ||
              out_item_i.probe_count !== exp_r.probe_count ||
              out_item_i.status !== exp_r.status) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("%0t: mismatch exp found=%0d count=%0d status=%0d, got %0d %0d %0d",
                       $realtime, exp_r.found, exp_r.probe_count, exp_r.status,
                       out_item_i.found, out_item_i.probe_count, out_item_i.status);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(walk_table(in_item_i));
      miss_cnt_o <= miss_cnt;
      pend_cnt_o <= expected_q.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Top of the double hash table testbench: clock, reset, stimulus and verdict.
// Instantiates double_hash_table and dht_checker; uses types from dht_pkg.
module tb import dht_pkg::*; ();

  localparam int unsigned TABLE_SIZE  = 1021;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int unsigned miss_cnt;
  int unsigned pend_cnt;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned burst_max  = 0;
  int unsigned gap_max    = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_run  = 0;
  int unsigned stall_left = 0;
  in_item_t    stored_q [$];

  double_hash_table #(.TABLE_SIZE(TABLE_SIZE)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  dht_checker #(.TABLE_SIZE(TABLE_SIZE)) chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .miss_cnt_o (miss_cnt),
    .pend_cnt_o (pend_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(99) < stall_pct);
      stall_left <= $urandom_range(stall_run);
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    if ($urandom_range(3) == 0) return KEY_W'($urandom_range(3 * TABLE_SIZE));
    return KEY_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    if ($urandom_range(3) == 0) return VAL_W'($urandom_range(15));
    return VAL_W'($urandom());
  endfunction

  task automatic send_item(logic [OPC_W-1:0] opc, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    in_item_t    it;
    int unsigned gap;
    it.opcode = opc;
    it.key    = k;
    it.value  = v;
    in_item <= it;
    if (!in_valid) in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (opc == OP_INSERT) stored_q.push_back(it);
    if (opc == OP_CLEAR) stored_q.delete();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // mix of inserts, searches, clears and unused opcodes; searches mostly reuse stored pairs so hits occur
  task automatic run_mixed(int unsigned n, int unsigned ins_pct, int unsigned clr_pct);
    int unsigned      roll;
    int unsigned      idx;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    repeat (n) begin
      roll = $urandom_range(99);
      k = rand_key();
      v = rand_val();
      if (roll < clr_pct) begin
        send_item(OP_CLEAR, k, v);
      end else if (roll < clr_pct + 3) begin
        send_item(OP_UNUSED, k, v);
      end else if (roll < clr_pct + 3 + ins_pct) begin
        send_item(OP_INSERT, k, v);
      end else begin
        if (stored_q.size() != 0 && $urandom_range(99) < 60) begin
          idx = $urandom_range(stored_q.size() - 1);
          k = stored_q[idx].key;
          v = stored_q[idx].value;
          if ($urandom_range(3) == 0) k = rand_key();
        end
        send_item(OP_SEARCH, k, v);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: empty table, extremes, collisions, step 17 and step 1, wrap, clear
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, KEY_MAX, VAL_MAX);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_SEARCH, KEY_MAX, VAL_MAX);
    send_item(OP_INSERT, '0, 31'd5);
    send_item(OP_INSERT, KEY_W'(TABLE_SIZE), 31'd6);
    send_item(OP_SEARCH, KEY_W'(TABLE_SIZE), 31'd6);
    send_item(OP_SEARCH, '0, 31'd6);
    send_item(OP_INSERT, 31'd16, 31'd9);
    send_item(OP_INSERT, 31'd16, 31'd9);
    send_item(OP_SEARCH, 31'd16, 31'd9);
    send_item(OP_SEARCH, 31'd17, 31'd1234);
    send_item(OP_UNUSED, KEY_MAX, VAL_MAX);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_SEARCH, KEY_MAX, VAL_MAX);
    send_item(OP_INSERT, KEY_W'(TABLE_SIZE - 1), 31'h2AAA_AAAA);
    send_item(OP_INSERT, KEY_W'(TABLE_SIZE - 1), 31'h5555_5555);
    send_item(OP_SEARCH, KEY_W'(TABLE_SIZE - 1), 31'h5555_5555);

    // back to back, no stalls
    run_mixed(150, 50, 2);

    burst_max = 12; gap_max = 20; stall_pct = 30; stall_run = 6;
    run_mixed(200, 60, 0);

    // fill the table completely, then hit the probe bound
    burst_max = 20; gap_max = 6; stall_pct = 15; stall_run = 3;
    send_item(OP_CLEAR, rand_key(), rand_val());
    repeat (TABLE_SIZE) send_item(OP_INSERT, rand_key(), rand_val());
    run_mixed(40, 40, 0);
    send_item(OP_CLEAR, rand_key(), rand_val());

    burst_max = 4; gap_max = 30; stall_pct = 60; stall_run = 25;
    run_mixed(100, 45, 3);

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pend_cnt != 0);
    repeat (2 * TABLE_SIZE + 32) @(posedge clk_i);
    if (miss_cnt == 0 && pend_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/dht_pkg.sv
src/dht_ram.sv
src/dht_datapath.sv
src/dht_ctrl.sv
src/double_hash_table.sv
test/dht_checker.sv
test/tb.sv
